// ===== sv/sgd_pkg.sv =====
// Shared types and constants for the Sobel gradient and direction block.
package sgd_pkg;

    localparam int unsigned MAX_WIDTH_DEFAULT = 1024;
    localparam int unsigned CFG_W             = 11;
    localparam int unsigned PIX_W             = 8;
    localparam int unsigned GRAD_W            = 11;
    localparam int unsigned MAG_W             = 8;
    localparam int unsigned SEC_W             = 2;
    localparam int unsigned OUT_DATA_W        = 32;
    localparam int unsigned ROOT_STEPS        = 8;

    localparam logic [CFG_W-1:0] WIDTH_RESET = 11'd640;
    localparam logic [CFG_W-1:0] WIDTH_MIN   = 11'd3;

    // tan 22.5 and tan 67.5 in Q8
    localparam logic [9:0] TAN_LOW_Q8  = 10'd106;
    localparam logic [9:0] TAN_HIGH_Q8 = 10'd618;

    typedef enum logic [SEC_W-1:0] {
        SEC_HORIZONTAL = 2'd0,
        SEC_DIAGONAL   = 2'd1,
        SEC_VERTICAL   = 2'd2,
        SEC_ANTI_DIAG  = 2'd3
    } sector_t;

endpackage

// ===== sv/sobel_gradient_direction.sv =====
// Sobel 3x3 gradient magnitude and direction over a raster pixel stream.
//
//  channel   | dir | handshake               | payload
//  ----------+-----+-------------------------+-----------------------------------------
//  s_axis    | in  | s_axis_tvalid/tready    | tdata: pixel; tuser: frame_start
//  m_axis    | out | m_axis_tvalid/tready    | tdata: magnitude, sector, grad_x, grad_y;
//            |     |                         | tlast: row_end
//  cfg       | in  | cfg_we                  | cfg_wdata: image_width
//
//  Pixels without a window result pass through the line store read, then the window update.
//  Pixels with a result go through read, update, squares, 8 root steps and output load.
//  The output register holds one result; while it is stalled the next result waits in S_OUT
//  with s_axis_tready low.
//  Line stores share one 16-bit synchronous RAM; no clearing pass after reset.
//  Reset clears counters, window columns, width (640) and handshake state.
module sobel_gradient_direction #(
    parameter int unsigned MAX_WIDTH = sgd_pkg::MAX_WIDTH_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [sgd_pkg::PIX_W-1:0]        s_axis_tdata,   // [7:0] pixel
    input  logic                             s_axis_tuser,   // [0] frame_start
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [7:0] magnitude, [9:8] direction_sector, [20:10] grad_x, [31:21] grad_y
    output logic [sgd_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    output logic                             m_axis_tlast,   // row_end
    input  logic                             cfg_we,
    input  logic [sgd_pkg::CFG_W-1:0]        cfg_wdata
);
    import sgd_pkg::*;

    localparam int unsigned CW = $clog2(MAX_WIDTH);
    localparam int unsigned EW = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
    localparam logic [EW-1:0] MAX_W_E = EW'(MAX_WIDTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CALC,
        S_SQUARE,
        S_ROOT,
        S_OUT
    } state_t;

    state_t state_reg;

    logic [CFG_W-1:0]     width_reg;
    logic [CW-1:0]        col_reg;
    logic [1:0]           rows_reg;
    logic [PIX_W-1:0]     pix_reg;
    logic [2*PIX_W-1:0]   rd_reg;
    logic [PIX_W-1:0]     win_reg [6];
    logic                 last_reg;
    logic signed [GRAD_W-1:0] gx_reg, gy_reg;
    logic                 sat_reg;
    logic [15:0]          rad_reg;
    logic [10:0]          rem_reg;
    logic [MAG_W-1:0]     root_reg;
    logic [2:0]           step_reg;
    sector_t              sec_reg;

    logic                 out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic                 out_last_reg;

    // line stores: [15:8] row above, [7:0] two rows above
    logic [2*PIX_W-1:0]   line_mem [MAX_WIDTH];

    logic                 accept;
    logic [CW-1:0]        rd_addr;
    logic [EW-1:0]        eff_w;
    logic [EW-1:0]        cfg_e;
    logic                 last;
    logic                 emit;
    logic [CW-1:0]        col_next;
    logic [1:0]           rows_next;

    logic [PIX_W-1:0]     t2, m2, b2;
    logic [9:0]           sx_r, sx_l, sy_t, sy_b;
    logic signed [GRAD_W-1:0] gx, gy;

    logic [9:0]           ax, ay;
    logic [20:0]          sq;
    logic [19:0]          a_q8, lo_q8, hi_q8;
    sector_t              sec;

    logic [10:0]          rem_sh, trial;
    logic                 out_free;

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign rd_addr       = s_axis_tuser ? '0 : col_reg;
    assign out_free      = !out_valid_reg || m_axis_tready;

    // effective width
    always_comb
    begin
        cfg_e = EW'(width_reg);
        if (width_reg < WIDTH_MIN)
            eff_w = EW'(WIDTH_MIN);
        else if (cfg_e > MAX_W_E)
            eff_w = MAX_W_E;
        else
            eff_w = cfg_e;
    end

    assign last      = (EW'(col_reg) + EW'(1)) >= eff_w;
    assign emit      = (rows_reg == 2'd2) && (col_reg >= CW'(2));
    assign col_next  = last ? '0 : col_reg + CW'(1);
    assign rows_next = (last && rows_reg != 2'd2) ? rows_reg + 2'd1 : rows_reg;

    // Sobel sums
    assign t2   = rd_reg[PIX_W-1:0];
    assign m2   = rd_reg[2*PIX_W-1:PIX_W];
    assign b2   = pix_reg;
    assign sx_r = 10'(t2) + {1'b0, m2, 1'b0} + 10'(b2);
    assign sx_l = 10'(win_reg[0]) + {1'b0, win_reg[1], 1'b0} + 10'(win_reg[2]);
    assign sy_t = 10'(win_reg[0]) + {1'b0, win_reg[3], 1'b0} + 10'(t2);
    assign sy_b = 10'(win_reg[2]) + {1'b0, win_reg[5], 1'b0} + 10'(b2);
    assign gx   = $signed({1'b0, sx_r}) - $signed({1'b0, sx_l});
    assign gy   = $signed({1'b0, sy_t}) - $signed({1'b0, sy_b});

    // squares and sector tests
    always_comb
    begin
        ax    = gx_reg[GRAD_W-1] ? 10'(-gx_reg) : 10'(gx_reg);
        ay    = gy_reg[GRAD_W-1] ? 10'(-gy_reg) : 10'(gy_reg);
        sq    = 21'(20'(ax) * 20'(ax)) + 21'(20'(ay) * 20'(ay));
        a_q8  = {2'b00, ay, 8'h00};
        lo_q8 = 20'(ax) * 20'(TAN_LOW_Q8);
        hi_q8 = 20'(ax) * 20'(TAN_HIGH_Q8);
        if (gx_reg == '0)
            sec = SEC_VERTICAL;
        else if (a_q8 <= lo_q8)
            sec = SEC_HORIZONTAL;
        else if (a_q8 > hi_q8)
            sec = SEC_VERTICAL;
        else if (gx_reg[GRAD_W-1] == gy_reg[GRAD_W-1])
            sec = SEC_DIAGONAL;
        else
            sec = SEC_ANTI_DIAG;
    end

    // one digit of the square root
    assign rem_sh = {rem_reg[8:0], rad_reg[15:14]};
    assign trial  = {1'b0, root_reg, 2'b01};

    // line store RAM
    always_ff @(posedge clk)
    begin
        if (accept)
            rd_reg <= line_mem[rd_addr];
        if (state_reg == S_CALC)
            line_mem[col_reg] <= {pix_reg, m2};
    end

    // datapath payload
    always_ff @(posedge clk)
    begin
        if (accept)
            pix_reg <= s_axis_tdata;
        if (state_reg == S_CALC)
        begin
            gx_reg   <= gx;
            gy_reg   <= gy;
            last_reg <= last;
        end
        if (state_reg == S_SQUARE)
        begin
            sat_reg  <= (sq[20:16] != '0);
            rad_reg  <= sq[15:0];
            rem_reg  <= '0;
            root_reg <= '0;
            sec_reg  <= sec;
        end
        if (state_reg == S_ROOT)
        begin
            rad_reg <= {rad_reg[13:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_reg  <= rem_sh - trial;
                root_reg <= {root_reg[MAG_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_sh;
                root_reg <= {root_reg[MAG_W-2:0], 1'b0};
            end
        end
    end

    // control and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            width_reg     <= WIDTH_RESET;
            col_reg       <= '0;
            rows_reg      <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            out_last_reg  <= 1'b0;
            for (int i = 0; i < 6; i++)
                win_reg[i] <= '0;
        end
        else
        begin
            if (cfg_we)
                width_reg <= cfg_wdata;
            if (state_reg == S_OUT && out_free)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && m_axis_tready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (s_axis_tuser)
                        begin
                            col_reg  <= '0;
                            rows_reg <= '0;
                        end
                        state_reg <= S_CALC;
                    end
                end
                S_CALC:
                begin
                    win_reg[0] <= win_reg[3];
                    win_reg[1] <= win_reg[4];
                    win_reg[2] <= win_reg[5];
                    win_reg[3] <= t2;
                    win_reg[4] <= m2;
                    win_reg[5] <= b2;
                    col_reg    <= col_next;
                    rows_reg   <= rows_next;
                    state_reg  <= emit ? S_SQUARE : S_IDLE;
                end
                S_SQUARE:
                begin
                    step_reg  <= '0;
                    state_reg <= S_ROOT;
                end
                S_ROOT:
                begin
                    step_reg <= step_reg + 3'd1;
                    if (step_reg == 3'(ROOT_STEPS - 1))
                        state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        out_data_reg  <= {gy_reg, gx_reg, sec_reg,
                                          sat_reg ? {MAG_W{1'b1}} : root_reg};
                        out_last_reg  <= last_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

`ifndef NO_ASSERTIONS
    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(col_reg) < MAX_WIDTH)
        else $error("column counter past line store depth");

    a_rows_sat: assert property (@(posedge clk) disable iff (!rst_n)
        rows_reg != 2'd3)
        else $error("row count past saturation");

    a_accept_calc: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == S_CALC)
        else $error("accepted pixel not followed by window update");

    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_OUT))
        else $error("result loaded outside output state");
`endif

endmodule
